### rtl/olist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants of the ordered list block: operation and status
// codes, controller states and the result record.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISPLAY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } olist_state_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic                last;
  } result_t;

endpackage

### rtl/ordered_list_append_delete_by_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_delete_by_key
// Ordered list of signed 32-bit values held compactly in one RAM, head at
// entry 0. Appends at the tail, deletes the first match with compaction, and
// reads the whole list out from head to tail.
//
//   Channel  Direction  Handshake                 Payload
//   in       in         in_valid_i / in_ready_o   func_i, value_i
//   out      out        out_valid_o / out_ready_i status_o, value_res_o, last_o
//
// A delete sweeps the RAM one entry per cycle, writing each later entry one
// place down. A read out sends one result per cycle while the output register
// is free, paced by the single RAM read port. The output register stalls the
// read-out sweep while results wait.
// Reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_list_append_delete_by_key #(
  parameter int unsigned CAPACITY = olist_pkg::DEF_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [olist_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [olist_pkg::DATA_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [olist_pkg::STATUS_W-1:0]      status_o,
  output logic signed [olist_pkg::DATA_W-1:0] value_res_o,
  output logic                                last_o
);

  import olist_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  olist_state_e state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [FUNC_W-1:0] op_q, op_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic              found_q, found_d;
  result_t           res_q, res_d;

  logic              in_fire;
  logic              last_idx;
  logic              match;
  logic              out_free;
  logic              push;
  result_t           push_res;
  result_t           out_res;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_idx   = ((CW'(idx_q) + CW'(1)) == count_q);
  assign match      = (ram_rdata == key_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (func_i == FUNC_APPEND) begin
            state_d = S_RESP;
          end else if (func_i == FUNC_DELETE || func_i == FUNC_DISPLAY) begin
            state_d = (count_q == '0) ? S_RESP : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (op_q == FUNC_DISPLAY) begin
          if (out_free && last_idx) begin
            state_d = S_IDLE;
          end
        end else if (last_idx) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    op_d      = op_q;
    key_d     = key_q;
    found_d   = found_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = value_i;
    ram_re    = 1'b0;
    ram_raddr = '0;
    push      = 1'b0;
    push_res  = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = func_i;
          key_d   = value_i;
          idx_d   = '0;
          found_d = 1'b0;
          unique case (func_i)
            FUNC_APPEND: begin
              if (count_q >= CAP_CNT) begin
                res_d = '{status: STATUS_FULL, value: value_i, last: 1'b1};
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
                res_d   = '{status: STATUS_OK, value: value_i, last: 1'b1};
              end
            end
            FUNC_DELETE: begin
              if (count_q == '0) begin
                res_d = '{status: STATUS_EMPTY, value: value_i, last: 1'b1};
              end else begin
                ram_re = 1'b1;
              end
            end
            FUNC_DISPLAY: begin
              if (count_q == '0) begin
                res_d = '{status: STATUS_EMPTY, value: '0, last: 1'b1};
              end else begin
                ram_re = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (op_q == FUNC_DISPLAY) begin
          push_res = '{status: STATUS_OK, value: ram_rdata, last: last_idx};
          if (out_free) begin
            push = 1'b1;
            if (!last_idx) begin
              ram_re    = 1'b1;
              ram_raddr = idx_q + AW'(1);
              idx_d     = idx_q + AW'(1);
            end
          end
        end else begin
          if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = idx_q - AW'(1);
            ram_wdata = ram_rdata;
          end
          found_d = found_q || match;
          if (!last_idx) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + AW'(1);
            idx_d     = idx_q + AW'(1);
          end else if (found_q || match) begin
            count_d = count_q - CW'(1);
            res_d   = '{status: STATUS_OK, value: key_q, last: 1'b1};
          end else begin
            res_d   = '{status: STATUS_NOTFOUND, value: key_q, last: 1'b1};
          end
        end
      end
      S_RESP: begin
        push = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    op_q    <= op_d;
    key_q   <= key_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  olist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  olist_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (push_res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign status_o    = out_res.status;
  assign value_res_o = out_res.value;
  assign last_o      = out_res.last;

endmodule

### rtl/olist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ram
// Generic single-write, single-read RAM with a registered read port. The read
// data holds its value while no read is requested.
// ----------------------------------------------------------------------------
module olist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/olist_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_out_reg
// One-entry output register. It holds a result until the downstream side
// takes it and reports when a new result may be loaded.
// ----------------------------------------------------------------------------
module olist_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  olist_pkg::result_t  res_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output olist_pkg::result_t  res_o
);

  import olist_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
